// ===== sv/bra_pkg.sv =====
package bra_pkg;

    localparam int VAL_W  = 64;
    localparam int MAXD_W = 16;
    localparam int NUM_W  = 48;
    localparam int ERR_W  = 34;
    localparam int PROD_W = VAL_W + MAXD_W;

    localparam logic [VAL_W-1:0] RECIP_LIMIT = 64'h0000_0000_7FFF_FFFF;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [MAXD_W-1:0] maxden;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [VAL_W-1:0]  num;
        logic [VAL_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [VAL_W-1:0]  quot;
        logic [VAL_W-1:0]  rem;
    } t_div_rsp;

    typedef struct packed {
        logic              start;
        logic [VAL_W-1:0]  x1;
        logic [MAXD_W-1:0] y1;
        logic [VAL_W-1:0]  x2;
        logic [MAXD_W-1:0] y2;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] p1;
        logic [PROD_W-1:0] p2;
    } t_mul_rsp;

endpackage

// ===== sv/bra_if.sv =====
interface bra_in_if import bra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  value;
    logic [MAXD_W-1:0] max_denominator;

    modport source (output valid, output value, output max_denominator, input ready);
    modport sink   (input valid, input value, input max_denominator, output ready);
endinterface

interface bra_out_if import bra_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [NUM_W-1:0]        numerator;
    logic [MAXD_W-1:0]       denominator;
    logic signed [ERR_W-1:0] approx_error;

    modport source (output valid, output numerator, output denominator,
                    output approx_error, input ready);
    modport sink   (input valid, input numerator, input denominator,
                    input approx_error, output ready);
endinterface

// ===== sv/bra_front.sv =====
module bra_front import bra_pkg::*; #(
    parameter int DW = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bra_in_if.sink       i_in,
    output logic         o_item_valid,
    output t_item        o_item,
    input  logic         i_item_pop
);
    localparam logic [MAXD_W-1:0] DMASK = {MAXD_W{1'b1}} >> (MAXD_W - DW);

    t_item       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push, pop;
    t_item       w_item;
    logic [MAXD_W-1:0] md;

    assign i_in.ready   = (r_cnt != 2'd2);
    assign push         = i_in.valid && i_in.ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_mem[r_rp];

    // zero limit acts as one
    always_comb begin
        md           = i_in.max_denominator & DMASK;
        w_item.value = i_in.value;
        w_item.maxden = (md == '0) ? MAXD_W'(1) : md;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== sv/bra_div.sv =====
module bra_div import bra_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int CW = $clog2(VAL_W + 1);

    logic             r_busy, r_done;
    logic [CW-1:0]    r_cnt;
    logic [VAL_W-1:0] r_n, r_d, r_rem, r_quot;
    logic [VAL_W:0]   rs, diff;

    assign rs   = {r_rem, r_n[VAL_W-1]};
    assign diff = rs - {1'b0, r_d};

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_n    <= i_req.num;
            r_d    <= i_req.den;
            r_rem  <= '0;
            r_quot <= '0;
            r_cnt  <= CW'(VAL_W);
        end else if (r_busy) begin
            r_n   <= {r_n[VAL_W-2:0], 1'b0};
            r_cnt <= r_cnt - CW'(1);
            if (!diff[VAL_W]) begin
                r_rem  <= diff[VAL_W-1:0];
                r_quot <= {r_quot[VAL_W-2:0], 1'b1};
            end else begin
                r_rem  <= rs[VAL_W-1:0];
                r_quot <= {r_quot[VAL_W-2:0], 1'b0};
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

// ===== sv/bra_mul.sv =====
module bra_mul import bra_pkg::*; #(
    parameter int DW = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);
    localparam int MW = VAL_W + DW;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [MW-1:0] r_x1, r_x2, r_acc1, r_acc2;
    logic [DW-1:0] r_y1, r_y2;

    assign o_rsp.done = r_done;
    assign o_rsp.p1   = PROD_W'(r_acc1);
    assign o_rsp.p2   = PROD_W'(r_acc2);

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x1   <= MW'(i_req.x1);
            r_x2   <= MW'(i_req.x2);
            r_y1   <= i_req.y1[DW-1:0];
            r_y2   <= i_req.y2[DW-1:0];
            r_acc1 <= '0;
            r_acc2 <= '0;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            if (r_y1[0]) begin
                r_acc1 <= r_acc1 + r_x1;
            end
            if (r_y2[0]) begin
                r_acc2 <= r_acc2 + r_x2;
            end
            r_x1  <= {r_x1[MW-2:0], 1'b0};
            r_x2  <= {r_x2[MW-2:0], 1'b0};
            r_y1  <= r_y1 >> 1;
            r_y2  <= r_y2 >> 1;
            r_cnt <= r_cnt - CW'(1);
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

// ===== sv/bra_back.sv =====
module bra_back import bra_pkg::*; #(
    parameter int FRAC_BITS = 32,
    parameter int DW        = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_item_valid,
    input  t_item      i_item,
    output logic       o_item_pop,
    output t_div_req   o_div_req,
    input  t_div_rsp   i_div_rsp,
    output t_mul_req   o_mul_req,
    input  t_mul_rsp   i_mul_rsp,
    bra_out_if.source  o_res
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DIVA_GO = 4'd1;
    localparam logic [3:0] S_DIVA_W  = 4'd2;
    localparam logic [3:0] S_MULA_GO = 4'd3;
    localparam logic [3:0] S_MULA_W  = 4'd4;
    localparam logic [3:0] S_T_GO    = 4'd5;
    localparam logic [3:0] S_T_W     = 4'd6;
    localparam logic [3:0] S_MULB_GO = 4'd7;
    localparam logic [3:0] S_MULB_W  = 4'd8;
    localparam logic [3:0] S_MULC_GO = 4'd9;
    localparam logic [3:0] S_MULC_W  = 4'd10;
    localparam logic [3:0] S_MULD_GO = 4'd11;
    localparam logic [3:0] S_MULD_W  = 4'd12;
    localparam logic [3:0] S_DIVE_GO = 4'd13;
    localparam logic [3:0] S_DIVE_W  = 4'd14;
    localparam logic [3:0] S_OUT     = 4'd15;

    logic [3:0]       r_state;
    logic [VAL_W-1:0] r_value, r_p, r_q, r_a, r_r, r_n0, r_n1, r_num2;
    logic [VAL_W-1:0] r_mag1, r_mag2, r_num, r_mag;
    logic [DW-1:0]    r_maxd, r_d0, r_d1, r_t, r_den2, r_den;
    logic             r_first, r_neg1, r_neg2, r_neg;
    logic             r_o_valid;
    logic [NUM_W-1:0]  r_o_num;
    logic [MAXD_W-1:0] r_o_den;
    logic [ERR_W-1:0]  r_o_err;

    logic [VAL_W-1:0] s_den, tn, diff1, diff2, e;
    logic             cont, huge;

    assign o_res.valid        = r_o_valid;
    assign o_res.numerator    = r_o_num;
    assign o_res.denominator  = r_o_den;
    assign o_res.approx_error = r_o_err;
    assign o_item_pop         = (r_state == S_IDLE) && i_item_valid;

    assign s_den = i_mul_rsp.p1[VAL_W-1:0] + VAL_W'(r_d1);
    assign cont  = (s_den <= VAL_W'(r_maxd));
    assign tn    = (r_d0 == '0) ? r_a : i_mul_rsp.p2[VAL_W-1:0];
    assign huge  = !r_first && ((i_div_rsp.quot > RECIP_LIMIT) ||
                   ((i_div_rsp.quot == RECIP_LIMIT) && (i_div_rsp.rem != '0)));
    assign diff1 = i_mul_rsp.p1[VAL_W-1:0] - (r_n0 << FRAC_BITS);
    assign diff2 = i_mul_rsp.p2[VAL_W-1:0] - (r_num2 << FRAC_BITS);
    assign e     = r_neg ? (VAL_W'(0) - i_div_rsp.quot) : i_div_rsp.quot;

    always_comb begin
        o_div_req = '0;
        o_mul_req = '0;
        unique case (r_state)
            S_DIVA_GO: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = r_p;
                o_div_req.den   = r_q;
            end
            S_T_GO: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = VAL_W'(r_maxd - r_d1);
                o_div_req.den   = VAL_W'(r_d0);
            end
            S_DIVE_GO: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = r_mag + VAL_W'(r_den >> 1);
                o_div_req.den   = VAL_W'(r_den);
            end
            S_MULA_GO: begin
                o_mul_req.start = 1'b1;
                o_mul_req.x1    = r_a;
                o_mul_req.y1    = MAXD_W'(r_d0);
                o_mul_req.x2    = r_n0;
                o_mul_req.y2    = MAXD_W'(r_a[DW-1:0]);
            end
            S_MULB_GO: begin
                o_mul_req.start = 1'b1;
                o_mul_req.x1    = r_n0;
                o_mul_req.y1    = MAXD_W'(r_t);
                o_mul_req.x2    = VAL_W'(r_d0);
                o_mul_req.y2    = MAXD_W'(r_t);
            end
            S_MULC_GO: begin
                o_mul_req.start = 1'b1;
                o_mul_req.x1    = r_value;
                o_mul_req.y1    = MAXD_W'(r_d0);
                o_mul_req.x2    = r_value;
                o_mul_req.y2    = MAXD_W'(r_den2);
            end
            S_MULD_GO: begin
                o_mul_req.start = 1'b1;
                o_mul_req.x1    = r_mag1;
                o_mul_req.y1    = MAXD_W'(r_den2);
                o_mul_req.x2    = r_mag2;
                o_mul_req.y2    = MAXD_W'(r_d0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_value <= i_item.value;
                        r_maxd  <= i_item.maxden[DW-1:0];
                        r_p     <= i_item.value;
                        r_q     <= VAL_W'(1) << FRAC_BITS;
                        r_n0    <= VAL_W'(1);
                        r_n1    <= '0;
                        r_d0    <= '0;
                        r_d1    <= DW'(1);
                        r_first <= 1'b1;
                        r_state <= S_DIVA_GO;
                    end
                end
                S_DIVA_GO: r_state <= S_DIVA_W;
                S_DIVA_W: begin
                    if (i_div_rsp.done) begin
                        r_a     <= i_div_rsp.quot;
                        r_r     <= i_div_rsp.rem;
                        r_state <= huge ? S_T_GO : S_MULA_GO;
                    end
                end
                S_MULA_GO: r_state <= S_MULA_W;
                S_MULA_W: begin
                    if (i_mul_rsp.done) begin
                        if (!cont) begin
                            r_state <= S_T_GO;
                        end else begin
                            r_n0 <= tn + r_n1;
                            r_n1 <= r_n0;
                            r_d0 <= s_den[DW-1:0];
                            r_d1 <= r_d0;
                            if (r_r == '0) begin
                                r_state <= S_T_GO;
                            end else begin
                                r_p     <= r_q;
                                r_q     <= r_r;
                                r_first <= 1'b0;
                                r_state <= S_DIVA_GO;
                            end
                        end
                    end
                end
                S_T_GO: r_state <= S_T_W;
                S_T_W: begin
                    if (i_div_rsp.done) begin
                        r_t     <= i_div_rsp.quot[DW-1:0];
                        r_state <= S_MULB_GO;
                    end
                end
                S_MULB_GO: r_state <= S_MULB_W;
                S_MULB_W: begin
                    if (i_mul_rsp.done) begin
                        r_num2  <= i_mul_rsp.p1[VAL_W-1:0] + r_n1;
                        r_den2  <= i_mul_rsp.p2[DW-1:0] + r_d1;
                        r_state <= S_MULC_GO;
                    end
                end
                S_MULC_GO: r_state <= S_MULC_W;
                S_MULC_W: begin
                    if (i_mul_rsp.done) begin
                        r_neg1  <= diff1[VAL_W-1];
                        r_neg2  <= diff2[VAL_W-1];
                        r_mag1  <= diff1[VAL_W-1] ? (VAL_W'(0) - diff1) : diff1;
                        r_mag2  <= diff2[VAL_W-1] ? (VAL_W'(0) - diff2) : diff2;
                        r_state <= S_MULD_GO;
                    end
                end
                S_MULD_GO: r_state <= S_MULD_W;
                S_MULD_W: begin
                    if (i_mul_rsp.done) begin
                        if (i_mul_rsp.p1 < i_mul_rsp.p2) begin
                            r_num <= r_n0;
                            r_den <= r_d0;
                            r_mag <= r_mag1;
                            r_neg <= r_neg1;
                        end else begin
                            r_num <= r_num2;
                            r_den <= r_den2;
                            r_mag <= r_mag2;
                            r_neg <= r_neg2;
                        end
                        r_state <= S_DIVE_GO;
                    end
                end
                S_DIVE_GO: r_state <= S_DIVE_W;
                S_DIVE_W: begin
                    if (i_div_rsp.done) begin
                        r_o_num   <= r_num[NUM_W-1:0];
                        r_o_den   <= MAXD_W'(r_den);
                        r_o_err   <= e[ERR_W-1:0];
                        r_o_valid <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_o_valid <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/best_rational_approximation.sv =====
// Best rational approximation p/q, q <= max_denominator, of an unsigned fixed
// point value with FRAC_BITS fraction bits, returned with the signed error
// (value - p/q, FRAC_BITS fraction bits, rounded half away from zero). A
// max_denominator of zero acts as one; numerator is kept modulo 2^48. Items
// queue two deep at the input and are processed one at a time. One 64-bit
// restoring divider and one shift-add multiplier are shared by all steps;
// the time an item takes grows with its number of continued-fraction terms.
module best_rational_approximation import bra_pkg::*; #(
    parameter int FRAC_BITS = 32,
    parameter int DEN_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bra_in_if.sink     i_in,
    bra_out_if.source  o_res
);
    localparam int DW = (DEN_BITS < MAXD_W) ? DEN_BITS : MAXD_W;

    logic     item_valid, item_pop;
    t_item    item;
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    bra_front #(.DW(DW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    bra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    bra_mul #(.DW(DW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    bra_back #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp),
        .o_mul_req    (mul_req),
        .i_mul_rsp    (mul_rsp),
        .o_res        (o_res)
    );
endmodule

// ===== tb/sv/best_rational_approximation_test.sv =====
`timescale 1ns / 100ps

module best_rational_approximation_test;
    import bra_pkg::*;

    localparam int FRAC_BITS = 32;
    localparam int LONG_HOLD = 8000;

    typedef struct {
        logic [NUM_W-1:0]        num;
        logic [MAXD_W-1:0]       den;
        logic signed [ERR_W-1:0] err;
    } t_approx;

    logic i_clk;
    logic i_rst_n;

    bra_in_if  in_if();
    bra_out_if res_if();

    best_rational_approximation i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    t_approx approx_q[$];
    int      fail_cnt;
    bit      rx_quiet;
    bit      rx_hold_req;
    int      rx_hold_cnt;
    int      rx_gap_cnt;
    bit      tx_quiet;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_approx predict_approx(bit [63:0] value, bit [15:0] maxd_in);
        bit [63:0]  lim, p, q, a, r, t, n0, n1, d0, d1;
        bit [63:0]  num1, den1, num2, den2, diff1, diff2, mag1, mag2, mag, den, num, e;
        bit [127:0] w1, w2;
        bit         neg1, neg2, neg;
        t_approx    res;
        lim = {48'b0, maxd_in};
        if (lim == 0) begin
            lim = 1;
        end
        p  = value;
        q  = 64'h1 << FRAC_BITS;
        a  = p / q;
        n0 = 1; n1 = 0; d0 = 0; d1 = 1;
        while (d0 * a + d1 <= lim) begin
            t = n0 * a + n1; n1 = n0; n0 = t;
            t = d0 * a + d1; d1 = d0; d0 = t;
            r = p % q;
            if (r == 0) begin
                break;
            end
            p = q;
            q = r;
            if (p > RECIP_LIMIT * q) begin
                break;
            end
            a = p / q;
        end
        num1 = n0; den1 = d0;
        t    = (lim - d1) / d0;
        num2 = n0 * t + n1;
        den2 = d0 * t + d1;
        diff1 = value * den1 - (num1 << FRAC_BITS);
        diff2 = value * den2 - (num2 << FRAC_BITS);
        neg1  = diff1[63];
        neg2  = diff2[63];
        mag1  = neg1 ? -diff1 : diff1;
        mag2  = neg2 ? -diff2 : diff2;
        w1 = {64'b0, mag1} * {64'b0, den2};
        w2 = {64'b0, mag2} * {64'b0, den1};
        if (w1 < w2) begin
            num = num1; den = den1; mag = mag1; neg = neg1;
        end else begin
            num = num2; den = den2; mag = mag2; neg = neg2;
        end
        e = (mag + den / 2) / den;
        if (neg) begin
            e = -e;
        end
        res.num = num[NUM_W-1:0];
        res.den = den[MAXD_W-1:0];
        res.err = e[ERR_W-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(20, 80);
        end
        return $urandom_range(0, 3);
    endfunction

    task automatic send_word(bit [63:0] value, bit [15:0] maxden);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid           <= 1'b1;
        in_if.value           <= value;
        in_if.max_denominator <= maxden;
        do @(posedge i_clk); while (!in_if.ready);
        approx_q.push_back(predict_approx(value, maxden));
        @(negedge i_clk);
    endtask

    function automatic bit [63:0] rand_value();
        bit [63:0] v;
        bit [31:0] nm, dn;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = {28'b0, 4'($urandom), $urandom};
            2: begin
                dn = $urandom_range(2, 70000);
                nm = $urandom_range(0, 4 * dn);
                v  = ({32'b0, nm} << FRAC_BITS) / {32'b0, dn};
            end
            3: v = {48'b0, 16'($urandom)};
            4: v = {$urandom, 32'b0} | 64'($urandom_range(0, 1));
            default: v = {32'($urandom_range(0, 3)), $urandom};
        endcase
        return v;
    endfunction

    function automatic bit [15:0] rand_maxden();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hFFFF;
            3, 4: return 16'($urandom_range(1, 300));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_word(64'h0, 16'hFFFF);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 16'h0001);
        send_word(64'h0000_0003_243F_6A88, 16'h0000);
        send_word(64'h0000_0003_243F_6A88, 16'h0001);
        send_word(64'h0000_0003_243F_6A88, 16'h0071);
        send_word(64'h0000_0003_243F_6A88, 16'hFFFF);
        send_word(64'h0000_0003_0000_0000, 16'hFFFF);
        send_word(64'h0000_0000_8000_0000, 16'h0001);
        send_word(64'h0000_0000_4000_0000, 16'h0002);
        send_word(64'h0000_0000_0000_0001, 16'hFFFF);
        send_word(64'h0000_0000_0000_0001, 16'h0001);
        send_word(64'h0000_0000_5555_5555, 16'hFFFF);
        send_word(64'h0000_0000_5555_5555, 16'h0003);
        send_word(64'h0000_0001_9E37_79B9, 16'hFFFF);
        send_word(64'hFFFF_FFFF_0000_0001, 16'hFFFF);
        send_word(64'h8000_0000_7FFF_FFFF, 16'hAAAA);
        send_word(64'h0000_0000_FFFF_FFFF, 16'h5555);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i == count / 3) begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end else if (i == count / 2) begin
                tx_quiet = 1'b0;
                rx_quiet = 1'b0;
            end
            send_word(rand_value(), rand_maxden());
        end
    endtask

    task automatic test_backpressure(int count);
        tx_quiet    = 1'b1;
        rx_hold_req = 1'b1;
        for (int i = 0; i < count; i++) begin
            send_word(rand_value(), rand_maxden());
        end
        tx_quiet = 1'b0;
    endtask

    // result port ready: random gaps, quiet stretches, and one long hold
    always @(negedge i_clk) begin
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt <= rx_hold_cnt - 1;
            res_if.ready <= 1'b0;
        end else if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_hold_cnt <= LONG_HOLD;
            res_if.ready <= 1'b0;
        end else if (rx_gap_cnt > 0) begin
            rx_gap_cnt <= rx_gap_cnt - 1;
            res_if.ready <= 1'b0;
        end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
            rx_gap_cnt <= pick_gap();
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_approx exp_w;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (approx_q.size() == 0) begin
                $display("%0t: unexpected word num=%h den=%h err=%h", $time,
                         res_if.numerator, res_if.denominator, res_if.approx_error);
                fail_cnt++;
            end else begin
                exp_w = approx_q.pop_front();
                if (res_if.numerator !== exp_w.num) begin
                    $display("%0t: numerator expected %h actual %h", $time,
                             exp_w.num, res_if.numerator);
                    fail_cnt++;
                end
                if (res_if.denominator !== exp_w.den) begin
                    $display("%0t: denominator expected %h actual %h", $time,
                             exp_w.den, res_if.denominator);
                    fail_cnt++;
                end
                if (res_if.approx_error !== exp_w.err) begin
                    $display("%0t: approx_error expected %h actual %h", $time,
                             exp_w.err, res_if.approx_error);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        fail_cnt              = 0;
        rx_quiet              = 1'b0;
        rx_hold_req           = 1'b0;
        rx_hold_cnt           = 0;
        rx_gap_cnt            = 0;
        tx_quiet              = 1'b0;
        i_rst_n               = 1'b0;
        in_if.valid           = 1'b0;
        in_if.value           = '0;
        in_if.max_denominator = '0;
        res_if.ready          = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(258);
        test_backpressure(14);

        in_if.valid <= 1'b0;
        while (approx_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/bra_pkg.sv
sv/bra_if.sv
sv/bra_front.sv
sv/bra_div.sv
sv/bra_mul.sv
sv/bra_back.sv
sv/best_rational_approximation.sv
tb/sv/best_rational_approximation_test.sv
